// ----- rtl/http_request_line_parser_defines.svh -----
// Assertion macros shared by the checker of the request line parser.
// No dependencies; include by bare file name.
`ifndef HTTP_REQUEST_LINE_PARSER_DEFINES_SVH
`define HTTP_REQUEST_LINE_PARSER_DEFINES_SVH

// Implication checked in the same cycle, disabled while reset is high.
`define HRLP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrlp assertion failed");

// Implication checked in the cycle after, disabled while reset is high.
`define HRLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrlp assertion failed");

// Implication checked in the cycle after, active during reset as well.
`define HRLP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hrlp assertion failed");

`endif

// ----- rtl/hrlp_pkg.sv -----
// Types, constants and the keep-alive literal of the request line parser.
// No dependencies.
package hrlp_pkg;

   // Default size of the request buffer in bytes.
   localparam int DEF_BUFFER_BYTES = 4096;

   // Length of the keep-alive literal and the width of the URL count.
   localparam int KA_LEN = 22;
   localparam int URL_WIDTH = 12;

   // Special bytes of the protocol.
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // The header text "Connection: keep-alive", one character per entry.
   localparam logic [7:0] KA_TEXT [KA_LEN] = '{
      8'h43, 8'h6F, 8'h6E, 8'h6E, 8'h65, 8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h3A,
      8'h20, 8'h6B, 8'h65, 8'h65, 8'h70, 8'h2D, 8'h61, 8'h6C, 8'h69, 8'h76, 8'h65
   };

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_URL        = 2'd0,
      KIND_DONE       = 2'd1,
      KIND_DONE_EMPTY = 2'd2,
      KIND_BAD        = 2'd3
   } res_kind_type;

   // Parse phase, one-hot.
   typedef enum logic [2:0] {
      PH_REQ_LINE = 3'b001,
      PH_HEADERS  = 3'b010,
      PH_DONE     = 3'b100
   } phase_type;

   // One result as it leaves the parse logic.
   typedef struct packed {
      logic                   valid;
      res_kind_type           kind;
      logic [7:0]             url_byte;
      logic [URL_WIDTH-1:0]   url_length;
      logic                   keep_alive;
   } result_type;

endpackage

// ----- rtl/hrlp_if.sv -----
// Valid/ready channel interfaces for request bytes and parse results.
// Depends on hrlp_pkg.
interface hrlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_request;

   modport source (output valid, output data_byte, output start_of_request, input ready);
   modport sink (input valid, input data_byte, input start_of_request, output ready);
endinterface

interface hrlp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     res_kind;
   logic [7:0]                     url_byte;
   logic [hrlp_pkg::URL_WIDTH-1:0] url_length;
   logic                           keep_alive;

   modport source (output valid, output res_kind, output url_byte, output url_length,
                   output keep_alive, input ready);
   modport sink (input valid, input res_kind, input url_byte, input url_length,
                 input keep_alive, output ready);
endinterface

// ----- rtl/hrlp_ka_match.sv -----
// Incremental matcher for the keep-alive header literal.
// Depends on hrlp_pkg.
module hrlp_ka_match (
   input  logic [7:0] data_byte,
   input  logic [4:0] match_pos,
   output logic [4:0] match_pos_next,
   output logic       hit
);

   logic [4:0] start_pos;
   logic [4:0] advanced;

   // Restart from zero if the position ran past the literal.
   always_comb begin
      start_pos = (match_pos >= 5'(hrlp_pkg::KA_LEN)) ? 5'd0 : match_pos;
      if (data_byte == hrlp_pkg::KA_TEXT[start_pos]) begin
         advanced = start_pos + 5'd1;
      end else if (data_byte == hrlp_pkg::KA_TEXT[0]) begin
         advanced = 5'd1;
      end else begin
         advanced = 5'd0;
      end
      // A full match raises the flag and starts over.
      hit = (advanced == 5'(hrlp_pkg::KA_LEN));
      match_pos_next = hit ? 5'd0 : advanced;
   end

endmodule

// ----- rtl/hrlp_core.sv -----
// Parse state and per-byte update logic of the request line parser.
// Depends on hrlp_pkg and hrlp_ka_match.
module hrlp_core #(
   parameter int BUFFER_BYTES = hrlp_pkg::DEF_BUFFER_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [7:0]           data_byte,
   input  logic                 start_of_request,
   output hrlp_pkg::result_type result
);

   localparam int CountWidth = $clog2(BUFFER_BYTES + 1);
   localparam int UrlWidth = hrlp_pkg::URL_WIDTH;

   hrlp_pkg::phase_type   phase_ff, phase_in, phase_eff;
   logic [1:0]            space_count_ff, space_count_in, space_count_eff;
   logic                  cr_pending_ff, cr_pending_in, cr_pending_eff;
   logic                  line_nonempty_ff, line_nonempty_in, line_nonempty_eff;
   logic [4:0]            match_pos_ff, match_pos_in, match_pos_eff;
   logic                  keep_alive_ff, keep_alive_in, keep_alive_eff;
   logic [UrlWidth-1:0]   url_count_ff, url_count_in, url_count_eff;
   logic [CountWidth-1:0] byte_count_ff, byte_count_in, byte_count_eff;
   logic [4:0]            match_pos_next;
   logic                  match_hit;

   // Start of request clears the state before the byte is looked at.
   always_comb begin
      if (start_of_request) begin
         phase_eff         = hrlp_pkg::PH_REQ_LINE;
         space_count_eff   = 2'd0;
         cr_pending_eff    = 1'b0;
         line_nonempty_eff = 1'b0;
         match_pos_eff     = 5'd0;
         keep_alive_eff    = 1'b0;
         url_count_eff     = '0;
         byte_count_eff    = '0;
      end else begin
         phase_eff         = phase_ff;
         space_count_eff   = space_count_ff;
         cr_pending_eff    = cr_pending_ff;
         line_nonempty_eff = line_nonempty_ff;
         match_pos_eff     = match_pos_ff;
         keep_alive_eff    = keep_alive_ff;
         url_count_eff     = url_count_ff;
         byte_count_eff    = byte_count_ff;
      end
   end

   hrlp_ka_match u_ka_match (
      .data_byte      (data_byte),
      .match_pos      (match_pos_eff),
      .match_pos_next (match_pos_next),
      .hit            (match_hit)
   );

   // Per-byte update: line splitting, URL extraction and header matching.
   always_comb begin
      phase_in          = phase_eff;
      space_count_in    = space_count_eff;
      cr_pending_in     = cr_pending_eff;
      line_nonempty_in  = line_nonempty_eff;
      match_pos_in      = match_pos_eff;
      keep_alive_in     = keep_alive_eff;
      url_count_in      = url_count_eff;
      byte_count_in     = byte_count_eff;
      result.valid      = 1'b0;
      result.kind       = hrlp_pkg::KIND_URL;
      result.url_byte   = 8'd0;
      result.url_length = url_count_eff;
      result.keep_alive = keep_alive_eff;

      // Bytes past the end of the buffer are dropped.
      if (byte_count_eff < CountWidth'(BUFFER_BYTES)) begin
         byte_count_in = byte_count_eff + CountWidth'(1);
         if (phase_eff != hrlp_pkg::PH_DONE) begin
            if (cr_pending_eff) begin
               cr_pending_in = 1'b0;
               if (data_byte != hrlp_pkg::CHAR_LF) begin
                  // A CR not followed by LF makes the request bad.
                  phase_in     = hrlp_pkg::PH_DONE;
                  result.valid = 1'b1;
                  result.kind  = hrlp_pkg::KIND_BAD;
               end else if (phase_eff == hrlp_pkg::PH_HEADERS && !line_nonempty_eff) begin
                  // An empty header line ends the request.
                  phase_in     = hrlp_pkg::PH_DONE;
                  result.valid = 1'b1;
                  result.kind  = (url_count_eff != '0) ? hrlp_pkg::KIND_DONE
                                                       : hrlp_pkg::KIND_DONE_EMPTY;
               end else begin
                  phase_in         = hrlp_pkg::PH_HEADERS;
                  line_nonempty_in = 1'b0;
                  match_pos_in     = 5'd0;
               end
            end else if (data_byte == hrlp_pkg::CHAR_CR) begin
               cr_pending_in = 1'b1;
            end else begin
               line_nonempty_in = 1'b1;
               if (phase_eff == hrlp_pkg::PH_REQ_LINE) begin
                  if (data_byte == hrlp_pkg::CHAR_SPACE) begin
                     if (space_count_eff != 2'd2) begin
                        space_count_in = space_count_eff + 2'd1;
                     end
                  end else if (space_count_eff == 2'd1) begin
                     // A byte between the first and second space is URL text.
                     url_count_in      = (url_count_eff != '1) ? url_count_eff + UrlWidth'(1)
                                                               : url_count_eff;
                     result.valid      = 1'b1;
                     result.kind       = hrlp_pkg::KIND_URL;
                     result.url_byte   = data_byte;
                     result.url_length = url_count_in;
                  end
               end else begin
                  match_pos_in = match_pos_next;
                  if (match_hit) begin
                     keep_alive_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   // State registers, updated once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= hrlp_pkg::PH_REQ_LINE;
         space_count_ff   <= 2'd0;
         cr_pending_ff    <= 1'b0;
         line_nonempty_ff <= 1'b0;
         match_pos_ff     <= 5'd0;
         keep_alive_ff    <= 1'b0;
         url_count_ff     <= '0;
         byte_count_ff    <= '0;
      end else if (go) begin
         phase_ff         <= phase_in;
         space_count_ff   <= space_count_in;
         cr_pending_ff    <= cr_pending_in;
         line_nonempty_ff <= line_nonempty_in;
         match_pos_ff     <= match_pos_in;
         keep_alive_ff    <= keep_alive_in;
         url_count_ff     <= url_count_in;
         byte_count_ff    <= byte_count_in;
      end
   end

endmodule

// ----- rtl/http_request_line_parser.sv -----
// The parser accepts one request byte per clock cycle while the result side is not stalled, and
// answers each byte with at most one result: a URL byte, a completion verdict or a bad-request
// verdict. A byte is registered on acceptance and its result enters the result register once that
// register can take it; the sustained rate is one byte per cycle while no stall holds the flow.
// Bytes that produce no result simply pass without a response, and a stalled result register holds
// the input side only once the input register is also full.
// Depends on hrlp_pkg, hrlp_if and hrlp_core.
module http_request_line_parser #(
   parameter int BUFFER_BYTES = hrlp_pkg::DEF_BUFFER_BYTES
) (
   input  logic      clock,
   input  logic      reset,
   hrlp_req_if.sink  req,
   hrlp_rsp_if.source rsp
);

   logic                 hold_valid_ff, hold_valid_in;
   logic [7:0]           hold_byte_ff;
   logic                 hold_sor_ff;
   logic                 proc_go;
   logic                 req_take;
   hrlp_pkg::result_type result;
   logic                 out_valid_ff, out_valid_in;
   hrlp_pkg::result_type out_ff;

   // The held byte is processed when the result register can take its outcome.
   assign proc_go   = hold_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !hold_valid_ff || proc_go;
   assign req_take  = req.valid && req.ready;

   // Input register.
   always_comb begin
      if (req_take) begin
         hold_valid_in = 1'b1;
      end else if (proc_go) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_byte_ff <= req.data_byte;
         hold_sor_ff  <= req.start_of_request;
      end
   end

   hrlp_core #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .go               (proc_go),
      .data_byte        (hold_byte_ff),
      .start_of_request (hold_sor_ff),
      .result           (result)
   );

   // Result register.
   always_comb begin
      if (proc_go) begin
         out_valid_in = result.valid;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_go && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.res_kind   = out_ff.kind;
   assign rsp.url_byte   = out_ff.url_byte;
   assign rsp.url_length = out_ff.url_length;
   assign rsp.keep_alive = out_ff.keep_alive;

endmodule

// ----- rtl/hrlp_checker.sv -----
// Port-level checks on the result channel of the request line parser, bound to the top level.
// Depends on hrlp_pkg and http_request_line_parser_defines.svh.
`include "http_request_line_parser_defines.svh"

module hrlp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [1:0]                     res_kind,
   input logic [7:0]                     url_byte,
   input logic [hrlp_pkg::URL_WIDTH-1:0] url_length
);

   logic                              rsp_stall;
   logic [hrlp_pkg::URL_WIDTH+9:0]    rsp_fields;
   logic                              url_fields_ok;
   logic                              done_seen;
   logic                              done_ok;

   // Terms shared by the checks below.
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_fields    = {res_kind, url_byte, url_length};
   assign url_fields_ok = (res_kind == hrlp_pkg::KIND_URL) ? (url_length != '0)
                                                           : (url_byte == 8'd0);
   assign done_seen     = rsp_valid && (res_kind == hrlp_pkg::KIND_DONE ||
                                        res_kind == hrlp_pkg::KIND_DONE_EMPTY);
   assign done_ok       = (res_kind == hrlp_pkg::KIND_DONE) == (url_length != '0);

   // A stalled result keeps its place and its content.
   `HRLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_fields))

   // Reset leaves no result pending.
   `HRLP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // Only URL results carry a byte, and a URL result always counts itself.
   `HRLP_ASSERT_SAME(a_url_fields, clock, reset, rsp_valid, url_fields_ok)

   // The completion kind agrees with the URL length.
   `HRLP_ASSERT_SAME(a_done_kind, clock, reset, done_seen, done_ok)

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .res_kind   (rsp.res_kind),
   .url_byte   (rsp.url_byte),
   .url_length (rsp.url_length)
);

// ----- dv/http_request_line_parser_test.sv -----
// Self-checking bench for http_request_line_parser: directed and random request streams,
// a per-byte parse predictor and an in-order result check. Depends on hrlp_pkg, hrlp_if
// and the parser RTL.
module http_request_line_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUFFER_BYTES   = hrlp_pkg::DEF_BUFFER_BYTES;
   localparam int RANDOM_BYTES   = 1330;
   localparam int LONG_URL_BYTES = 300;
   localparam int LONG_AT_BYTES  = 600;
   localparam int IDLE_PERCENT   = 14;
   localparam int QUIET_START    = 1000;
   localparam int QUIET_END      = 1300;
   localparam int HOLD_START     = 500;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 16;
   localparam int CYCLE_LIMIT    = 100000;
   localparam string KA_HEADER   = "Connection: keep-alive";

   // One request byte as offered to the parser.
   typedef struct {
      logic [7:0] data_byte;
      logic       start_of_request;
   } request_byte_type;

   // One result as the parser should deliver it.
   typedef struct {
      hrlp_pkg::res_kind_type         kind;
      logic [7:0]                     url_byte;
      logic [hrlp_pkg::URL_WIDTH-1:0] url_length;
      logic                           keep_alive;
   } parse_result_type;

   logic clock;
   logic reset;

   hrlp_req_if req_ch ();
   hrlp_rsp_if rsp_ch ();

   http_request_line_parser #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   request_byte_type pending_bytes[$];
   parse_result_type expected_results[$];
   int               cycle_count    = 0;
   int               items_accepted = 0;
   int               total_items    = 0;
   int               error_count    = 0;
   int               hold_left      = 0;
   logic             req_accepted   = 1'b0;
   logic             next_sor;

   // Parse state of the predictor.
   hrlp_pkg::phase_type            parse_phase;
   logic [1:0]                     space_count;
   logic                           cr_pending;
   logic                           line_nonempty;
   logic [4:0]                     match_pos;
   logic                           keep_alive_seen;
   logic [hrlp_pkg::URL_WIDTH-1:0] url_count;
   logic [12:0]                    byte_count;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Reset first, with every input at a known value from time zero.
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.start_of_request = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic bit in_quiet_window();
      return (cycle_count >= QUIET_START && cycle_count < QUIET_END) ||
             (cycle_count >= HOLD_START - 20 && cycle_count < HOLD_START + HOLD_CYCLES + 50);
   endfunction

   task automatic clear_parse_state();
      parse_phase = hrlp_pkg::PH_REQ_LINE;
      space_count = 2'd0;
      cr_pending = 1'b0;
      line_nonempty = 1'b0;
      match_pos = 5'd0;
      keep_alive_seen = 1'b0;
      url_count = '0;
      byte_count = 13'd0;
   endtask

   task automatic record_result(input hrlp_pkg::res_kind_type kind, input logic [7:0] ubyte);
      parse_result_type r;
      r.kind = kind;
      r.url_byte = ubyte;
      r.url_length = url_count;
      r.keep_alive = keep_alive_seen;
      expected_results.push_back(r);
   endtask

   // Predicts the parser's reaction to one accepted request byte.
   task automatic parse_byte(input logic [7:0] b, input logic sor);
      if (sor)
         clear_parse_state();
      // Bytes beyond the buffer are dropped without any effect.
      if (byte_count >= BUFFER_BYTES)
         return;
      byte_count++;
      if (parse_phase == hrlp_pkg::PH_DONE)
         return;

      // The byte after a CR must be LF; an LF ends the line.
      if (cr_pending) begin
         cr_pending = 1'b0;
         if (b != hrlp_pkg::CHAR_LF) begin
            parse_phase = hrlp_pkg::PH_DONE;
            record_result(hrlp_pkg::KIND_BAD, 8'h00);
            return;
         end
         if (parse_phase == hrlp_pkg::PH_HEADERS && !line_nonempty) begin
            parse_phase = hrlp_pkg::PH_DONE;
            if (url_count != 0)
               record_result(hrlp_pkg::KIND_DONE, 8'h00);
            else
               record_result(hrlp_pkg::KIND_DONE_EMPTY, 8'h00);
            return;
         end
         parse_phase = hrlp_pkg::PH_HEADERS;
         line_nonempty = 1'b0;
         match_pos = 5'd0;
         return;
      end
      if (b == hrlp_pkg::CHAR_CR) begin
         cr_pending = 1'b1;
         return;
      end
      line_nonempty = 1'b1;

      // Request line: the URL lies between the first and the second space.
      if (parse_phase == hrlp_pkg::PH_REQ_LINE) begin
         if (b == hrlp_pkg::CHAR_SPACE) begin
            if (space_count < 2'd2)
               space_count++;
            return;
         end
         if (space_count == 2'd1) begin
            if (url_count != '1)
               url_count++;
            record_result(hrlp_pkg::KIND_URL, b);
         end
         return;
      end

      // Header line: search for the keep-alive text.
      if (match_pos >= hrlp_pkg::KA_LEN)
         match_pos = 5'd0;
      if (b == hrlp_pkg::KA_TEXT[match_pos])
         match_pos++;
      else
         match_pos = (b == hrlp_pkg::KA_TEXT[0]) ? 5'd1 : 5'd0;
      if (match_pos >= hrlp_pkg::KA_LEN) begin
         keep_alive_seen = 1'b1;
         match_pos = 5'd0;
      end
   endtask

   // Request driver: a new byte or an idle cycle once the current one is taken.
   always @(negedge clock) begin
      request_byte_type item;
      if (reset !== 1'b0) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_accepted) begin
         if (pending_bytes.size() != 0 &&
             (in_quiet_window() || $urandom_range(99) >= IDLE_PERCENT)) begin
            item = pending_bytes.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.data_byte <= item.data_byte;
            req_ch.start_of_request <= item.start_of_request;
         end else begin
            req_ch.valid <= 1'b0;
            req_ch.data_byte <= 8'($urandom);
            req_ch.start_of_request <= 1'($urandom);
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off that backs up the input.
   always @(negedge clock) begin
      if (reset !== 1'b0) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (cycle_count == HOLD_START) begin
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= in_quiet_window() || $urandom_range(99) >= IDLE_PERCENT;
      end
   end

   // Monitor: predict on each accepted request, check each accepted result.
   always @(posedge clock) begin
      parse_result_type want;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            parse_byte(req_ch.data_byte, req_ch.start_of_request);
            items_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: res_kind %0d url_byte %h", rsp_ch.res_kind,
                      rsp_ch.url_byte);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.res_kind !== want.kind) begin
                  $error("res_kind: expected %0d, actual %0d", want.kind, rsp_ch.res_kind);
                  error_count++;
               end
               if (rsp_ch.url_byte !== want.url_byte) begin
                  $error("url_byte: expected %h, actual %h", want.url_byte, rsp_ch.url_byte);
                  error_count++;
               end
               if (rsp_ch.url_length !== want.url_length) begin
                  $error("url_length: expected %0d, actual %0d", want.url_length,
                         rsp_ch.url_length);
                  error_count++;
               end
               if (rsp_ch.keep_alive !== want.keep_alive) begin
                  $error("keep_alive: expected %0d, actual %0d", want.keep_alive,
                         rsp_ch.keep_alive);
                  error_count++;
               end
            end
         end
      end
   end

   // Stimulus helpers. The first byte of a request carries start_of_request.
   task automatic push_byte(input logic [7:0] b);
      request_byte_type item;
      item.data_byte = b;
      item.start_of_request = next_sor;
      pending_bytes.push_back(item);
      next_sor = 1'b0;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endtask

   // A line ending: CR then LF.
   task automatic push_crlf();
      push_byte(hrlp_pkg::CHAR_CR);
      push_byte(hrlp_pkg::CHAR_LF);
   endtask

   function automatic logic [7:0] rand_url_byte();
      logic [7:0] b;
      if ($urandom_range(3) != 0)
         return 8'($urandom_range(33, 126));
      do
         b = 8'($urandom);
      while (b == hrlp_pkg::CHAR_SPACE || b == hrlp_pkg::CHAR_CR);
      return b;
   endfunction

   function automatic logic [7:0] rand_line_byte();
      logic [7:0] b;
      do
         b = 8'($urandom);
      while (b == hrlp_pkg::CHAR_CR);
      return b;
   endfunction

   // A CR followed by anything but LF, another CR included.
   task automatic push_bad_cr();
      logic [7:0] b;
      push_byte(hrlp_pkg::CHAR_CR);
      do
         b = $urandom_range(3) == 0 ? hrlp_pkg::CHAR_CR : 8'($urandom);
      while (b == hrlp_pkg::CHAR_LF);
      push_byte(b);
   endtask

   task automatic push_header_line();
      case ($urandom_range(5))
         0: push_text(KA_HEADER);
         1: begin
            repeat ($urandom_range(1, 4)) push_byte(rand_line_byte());
            push_text(KA_HEADER);
            repeat ($urandom_range(0, 4)) push_byte(rand_line_byte());
         end
         2: push_text({"Conn", KA_HEADER});
         3: push_text(KA_HEADER.substr(0, KA_HEADER.len() - 2));
         4: push_text("Connection: close");
         default: repeat ($urandom_range(1, 10)) push_byte(rand_line_byte());
      endcase
   endtask

   // A request line and headers; a broken one has a bad CR at a random line end.
   task automatic add_request(input bit broken);
      int unsigned n_headers;
      int unsigned break_stage;
      next_sor = 1'b1;
      n_headers = $urandom_range(0, 3);
      break_stage = broken ? $urandom_range(0, n_headers) : n_headers + 1;
      repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(65, 90)));
      if ($urandom_range(9) != 0) begin
         push_byte(hrlp_pkg::CHAR_SPACE);
         repeat ($urandom_range(0, 12)) push_byte(rand_url_byte());
         case ($urandom_range(2))
            0: push_text(" HTTP/1.1");
            1: push_text(" a  b");
            default: ;
         endcase
      end
      if (break_stage == 0) begin
         push_bad_cr();
         return;
      end
      push_crlf();
      for (int h = 1; h <= n_headers; h++) begin
         push_header_line();
         if (break_stage == h) begin
            push_bad_cr();
            return;
         end
         push_crlf();
      end
      push_crlf();
      // Bytes after the verdict are ignored.
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
   endtask

   // Stimulus, then drain and verdict.
   initial begin
      int unsigned style;
      int          target;
      bit          long_added;
      clear_parse_state();
      long_added = 1'b0;

      // Empty request line, then an empty header line.
      next_sor = 1'b1;
      push_crlf();
      push_crlf();
      // Request line without a space, then a byte after the verdict.
      next_sor = 1'b1;
      push_text("G");
      push_crlf();
      push_crlf();
      push_text("x");
      // Lone LF and extreme bytes in the URL, second space, CR followed by CR.
      next_sor = 1'b1;
      push_byte(hrlp_pkg::CHAR_SPACE);
      push_byte(hrlp_pkg::CHAR_LF);
      push_byte(8'hFF);
      push_byte(hrlp_pkg::CHAR_SPACE);
      push_byte(hrlp_pkg::CHAR_CR);
      push_byte(hrlp_pkg::CHAR_CR);
      // One-byte URL of zero, completed request.
      next_sor = 1'b1;
      push_byte(hrlp_pkg::CHAR_SPACE);
      push_byte(8'h00);
      push_crlf();
      push_crlf();

      target = pending_bytes.size() + RANDOM_BYTES;
      while (pending_bytes.size() < target) begin
         // One long URL in a single request.
         if (!long_added && pending_bytes.size() > LONG_AT_BYTES) begin
            long_added = 1'b1;
            next_sor = 1'b1;
            push_byte(hrlp_pkg::CHAR_SPACE);
            repeat (LONG_URL_BYTES) push_byte(rand_url_byte());
            push_crlf();
            push_crlf();
         end
         style = $urandom_range(99);
         if (style < 75) begin
            add_request(1'b0);
         end else if (style < 90) begin
            add_request(1'b1);
         end else begin
            repeat ($urandom_range(1, 8)) begin
               next_sor = 1'($urandom_range(1));
               push_byte(8'($urandom));
            end
         end
      end
      total_items = pending_bytes.size();

      while (items_accepted < total_items) @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("http_request_line_parser_test: clean");
      else
         $display("http_request_line_parser_test: errors");
      $finish;
   end

   // Watchdog on the cycle count.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(negedge clock);
      $display("http_request_line_parser_test: errors");
      $finish;
   end

endmodule
